// ===== sv/stable_priority_message_queue_top_defines.svh =====
// Assertion macros for the stable priority message queue.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef STABLE_PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH
`define STABLE_PRIORITY_MESSAGE_QUEUE_TOP_DEFINES_SVH

// same-cycle implication
`define SPMQ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SPMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spmq_pkg.sv =====
// Package for the stable priority message queue: command and status codes,
// default depth and the controller/datapath link types. No dependencies.
`timescale 1ns / 1ps
package spmq_pkg;

	localparam int QUEUE_DEPTH_DEF = 16;
	localparam int COUNT_OUT_W     = 5;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_DEQUEUE = 2'd1,
		CMD_PEEK    = 2'd2,
		CMD_CLEAR   = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic load;
		logic exec;
	} ctl_cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} dp_sts_t;

endpackage

// ===== sv/spmq_in_if.sv =====
// Command channel interface of the message queue.
// Depends on spmq_pkg.
`timescale 1ns / 1ps
interface spmq_in_if;
	logic                valid;
	logic                ready;
	spmq_pkg::command_t  command;
	logic [15:0]         message_tag;
	logic                message_kind;
	logic [7:0]          message_priority;

	modport source (output valid, output command, output message_tag,
		output message_kind, output message_priority, input ready);
	modport sink (input valid, input command, input message_tag,
		input message_kind, input message_priority, output ready);
endinterface

// ===== sv/spmq_out_if.sv =====
// Result channel interface of the message queue.
// Depends on spmq_pkg.
`timescale 1ns / 1ps
interface spmq_out_if;
	logic                valid;
	logic                ready;
	spmq_pkg::status_t   status;
	logic [15:0]         head_tag;
	logic                head_kind;
	logic [7:0]          head_priority;
	logic [4:0]          entry_count;

	modport source (output valid, output status, output head_tag, output head_kind,
		output head_priority, output entry_count, input ready);
	modport sink (input valid, input status, input head_tag, input head_kind,
		input head_priority, input entry_count, output ready);
endinterface

// ===== sv/stable_priority_message_queue_top.sv =====
// Top level of the stable priority message queue: controller, datapath, assertions.
// Depends on spmq_pkg, spmq_in_if, spmq_out_if, spmq_ctrl, spmq_datapath and the defines header.
//
//  channel   | dir | payload
//  ----------+-----+--------------------------------------------------------------
//  in_msg    | in  | command, message_tag, message_kind, message_priority
//  out_msg   | out | status, head_tag, head_kind, head_priority, entry_count
//
// A transaction first latches the command, then updates the
// slot row, where every slot compares and shifts in parallel.
// The result register frees the input side; a stalled result holds the update back.
// Reset clears the entry count and the handshake state; slot contents are left as they are.
`timescale 1ns / 1ps
`include "stable_priority_message_queue_top_defines.svh"
module stable_priority_message_queue_top #(
	parameter int QUEUE_DEPTH = spmq_pkg::QUEUE_DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	spmq_in_if.sink    in_msg,
	spmq_out_if.source out_msg
);
	import spmq_pkg::*;

	ctl_cmd_t ctl_cmd;
	dp_sts_t  dp_sts;

	spmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_msg.valid),
		.in_ready  (in_msg.ready),
		.out_valid (out_msg.valid),
		.out_ready (out_msg.ready),
		.cmd       (ctl_cmd)
	);

	spmq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.in_command   (in_msg.command),
		.in_tag       (in_msg.message_tag),
		.in_kind      (in_msg.message_kind),
		.in_priority  (in_msg.message_priority),
		.res_status   (out_msg.status),
		.res_tag      (out_msg.head_tag),
		.res_kind     (out_msg.head_kind),
		.res_priority (out_msg.head_priority),
		.res_count    (out_msg.entry_count)
	);

	`SPMQ_ASSERT_NEXT(a_accept_then_busy, in_msg.valid && in_msg.ready, !in_msg.ready, "input taken while executing")
	`SPMQ_ASSERT_NOW(a_no_load_and_exec, ctl_cmd.exec, !ctl_cmd.load, "latch and execute overlap")
	`SPMQ_ASSERT_NOW(a_full_report, out_msg.valid && (out_msg.status == ST_FULL), dp_sts.full, "full reported on a queue with room")
	`SPMQ_ASSERT_NOW(a_empty_report, out_msg.valid && (out_msg.status == ST_EMPTY), dp_sts.empty, "empty reported on a non-empty queue")

endmodule

// ===== sv/spmq_ctrl.sv =====
// Controller of the message queue: command latch and execute sequencing,
// result valid flag. Depends on spmq_pkg.
`timescale 1ns / 1ps
module spmq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output spmq_pkg::ctl_cmd_t cmd
);
	import spmq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_exec;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign can_exec  = !out_valid_q || out_ready;
	assign cmd.load  = (state_q == S_IDLE) && in_valid;
	assign cmd.exec  = (state_q == S_EXEC) && can_exec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (out_valid_q && out_ready)
						out_valid_q <= 1'b0;
					if (in_valid)
						state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (can_exec) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// ===== sv/spmq_datapath.sv =====
// Datapath of the message queue: sorted slot row with per-slot compare and
// shift, entry count and result register. Depends on spmq_pkg.
`timescale 1ns / 1ps
module spmq_datapath #(
	parameter int QUEUE_DEPTH = spmq_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  spmq_pkg::ctl_cmd_t cmd,
	output spmq_pkg::dp_sts_t  sts,
	input  spmq_pkg::command_t in_command,
	input  logic [15:0]        in_tag,
	input  logic               in_kind,
	input  logic [7:0]         in_priority,
	output spmq_pkg::status_t  res_status,
	output logic [15:0]        res_tag,
	output logic               res_kind,
	output logic [7:0]         res_priority,
	output logic [4:0]         res_count
);
	import spmq_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	command_t    cmd_q;
	logic [15:0] tag_q;
	logic        kind_q;
	logic [7:0]  prio_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_nxt;
	logic [7:0]    slot_prio_q [QUEUE_DEPTH];
	logic [15:0]   slot_tag_q  [QUEUE_DEPTH];
	logic          slot_kind_q [QUEUE_DEPTH];

	logic [QUEUE_DEPTH-1:0] behind;
	logic full, empty, do_ins, do_del;

	status_t     st_nxt;
	logic        with_head;
	logic [15:0] rtag_q;
	logic        rkind_q;
	logic [7:0]  rprio_q;
	status_t     rstat_q;
	logic [COUNT_OUT_W-1:0] rcount_q;

	assign full  = (count_q == CW'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign sts.full  = full;
	assign sts.empty = empty;

	assign do_ins = cmd.exec && (cmd_q == CMD_ENQUEUE) && !full;
	assign do_del = cmd.exec && (cmd_q == CMD_DEQUEUE) && !empty;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_command;
			tag_q  <= in_tag;
			kind_q <= in_kind;
			prio_q <= in_priority;
		end
	end

	// slot i is at or behind the insert point: empty, or holds a larger priority
	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_slot
			assign behind[gi] = (CW'(gi) >= count_q) || (slot_prio_q[gi] > prio_q);

			always_ff @(posedge clk) begin
				if (do_ins && behind[gi]) begin
					if (gi == 0) begin
						slot_prio_q[gi] <= prio_q;
						slot_tag_q[gi]  <= tag_q;
						slot_kind_q[gi] <= kind_q;
					end else if (!behind[(gi == 0) ? 0 : gi - 1]) begin
						slot_prio_q[gi] <= prio_q;
						slot_tag_q[gi]  <= tag_q;
						slot_kind_q[gi] <= kind_q;
					end else begin
						slot_prio_q[gi] <= slot_prio_q[(gi == 0) ? 0 : gi - 1];
						slot_tag_q[gi]  <= slot_tag_q[(gi == 0) ? 0 : gi - 1];
						slot_kind_q[gi] <= slot_kind_q[(gi == 0) ? 0 : gi - 1];
					end
				end else if (do_del && (gi < QUEUE_DEPTH - 1)) begin
					slot_prio_q[gi] <= slot_prio_q[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
					slot_tag_q[gi]  <= slot_tag_q[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
					slot_kind_q[gi] <= slot_kind_q[(gi < QUEUE_DEPTH - 1) ? gi + 1 : gi];
				end
			end
		end
	endgenerate

	always_comb begin
		count_nxt = count_q;
		st_nxt    = ST_OK;
		with_head = 1'b0;
		case (cmd_q)
			CMD_ENQUEUE: begin
				if (full)
					st_nxt = ST_FULL;
				else
					count_nxt = count_q + CW'(1);
			end
			CMD_DEQUEUE: begin
				if (empty) begin
					st_nxt = ST_EMPTY;
				end else begin
					with_head = 1'b1;
					count_nxt = count_q - CW'(1);
				end
			end
			CMD_PEEK: begin
				if (empty)
					st_nxt = ST_EMPTY;
				else
					with_head = 1'b1;
			end
			CMD_CLEAR: count_nxt = '0;
			default:   count_nxt = count_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (cmd.exec)
			count_q <= count_nxt;
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rstat_q  <= st_nxt;
			rtag_q   <= with_head ? slot_tag_q[0]  : 16'd0;
			rkind_q  <= with_head ? slot_kind_q[0] : 1'b0;
			rprio_q  <= with_head ? slot_prio_q[0] : 8'd0;
			rcount_q <= COUNT_OUT_W'(count_nxt);
		end
	end

	assign res_status   = rstat_q;
	assign res_tag      = rtag_q;
	assign res_kind     = rkind_q;
	assign res_priority = rprio_q;
	assign res_count    = rcount_q;

endmodule
